// ===== hw/rtl/delta_byte_packer_macros.svh =====
// Assertion helpers for the delta byte packer.
`ifndef DELTA_BYTE_PACKER_MACROS_SVH
`define DELTA_BYTE_PACKER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define DBP_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: lhs implies rhs");

// Next-cycle implication.
`define DBP_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: lhs implies rhs next cycle");

`else

`define DBP_ASSERT_IMPLIES(label, clk, rst, lhs, rhs)
`define DBP_ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

// ===== hw/rtl/dbp_pkg.sv =====
package dbp_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int DIFF_WIDTH   = SAMPLE_WIDTH + 1;
   localparam int BYTE_WIDTH   = 8;
   localparam int COUNT_WIDTH  = 2;
   localparam int CSR_IDX_WIDTH = 1;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ONE_BYTE_LIMIT = 1'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TWO_BYTE_LIMIT = 1'd1;

   // Limit register reset values
   localparam logic [SAMPLE_WIDTH-1:0] ONE_BYTE_LIMIT_RST = 24'h00007F;
   localparam logic [SAMPLE_WIDTH-1:0] TWO_BYTE_LIMIT_RST = 24'h0007FF;

   // Width codes
   localparam logic [COUNT_WIDTH-1:0] WIDTH_ONE   = 2'd1;
   localparam logic [COUNT_WIDTH-1:0] WIDTH_TWO   = 2'd2;
   localparam logic [COUNT_WIDTH-1:0] WIDTH_THREE = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           first_of_block;
   } req_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]  out_byte;
      logic [COUNT_WIDTH-1:0] width_code;
      logic                   last_of_run;
   } rsp_type;

   // One queued sample: bytes to send and how many
   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] value;
      logic [COUNT_WIDTH-1:0]  count;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== hw/rtl/dbp_front.sv =====
module dbp_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   input  dbp_pkg::req_type                     req_data,
   output logic                                 req_full,
   input  logic                                 csr_valid,
   input  logic [dbp_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [dbp_pkg::SAMPLE_WIDTH-1:0]     csr_wdata,
   input  dbp_pkg::queue_status_type            q_status,
   output logic                                 q_push,
   output dbp_pkg::entry_type                   q_wdata
);
   import dbp_pkg::*;

   logic [SAMPLE_WIDTH-1:0] one_limit_ff, one_limit_in;
   logic [SAMPLE_WIDTH-1:0] two_limit_ff, two_limit_in;
   logic [SAMPLE_WIDTH-1:0] prev_ff, prev_in;
   logic                    stg_valid_ff, stg_valid_in;
   logic                    stg_first_ff, stg_first_in;
   logic [DIFF_WIDTH-1:0]   stg_diff_ff, stg_diff_in;
   logic [SAMPLE_WIDTH-1:0] stg_value_ff, stg_value_in;

   logic                    stg_free;
   logic                    accept;
   logic [DIFF_WIDTH-1:0]   diff;
   logic [DIFF_WIDTH-1:0]   adiff;
   logic [COUNT_WIDTH-1:0]  count;

   // Stage moves on when empty or when the queue takes its entry
   assign stg_free = !stg_valid_ff || !q_status.full;
   assign req_full = !stg_free;
   assign accept   = req_push && stg_free;
   assign q_push   = stg_valid_ff && !q_status.full;

   // Exact difference on sign-extended samples
   assign diff = {req_data.sample[SAMPLE_WIDTH-1], req_data.sample}
               - {prev_ff[SAMPLE_WIDTH-1], prev_ff};

   // Classify the staged difference against the limits
   always_comb begin
      adiff = stg_diff_ff[DIFF_WIDTH-1] ? (~stg_diff_ff + DIFF_WIDTH'(1)) : stg_diff_ff;
      if (stg_first_ff) begin
         count = WIDTH_THREE;
      end else if (adiff < {1'b0, one_limit_ff}) begin
         count = WIDTH_ONE;
      end else if (adiff < {1'b0, two_limit_ff}) begin
         count = WIDTH_TWO;
      end else begin
         count = WIDTH_THREE;
      end
   end

   assign q_wdata.value = stg_value_ff;
   assign q_wdata.count = count;

   // Next state of limits, history and stage
   always_comb begin
      one_limit_in = one_limit_ff;
      two_limit_in = two_limit_ff;
      prev_in      = prev_ff;
      stg_valid_in = stg_valid_ff;
      stg_first_in = stg_first_ff;
      stg_diff_in  = stg_diff_ff;
      stg_value_in = stg_value_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ONE_BYTE_LIMIT: one_limit_in = csr_wdata;
            CSR_TWO_BYTE_LIMIT: two_limit_in = csr_wdata;
            default: ;
         endcase
      end
      if (accept) begin
         prev_in      = req_data.sample;
         stg_valid_in = 1'b1;
         stg_first_in = req_data.first_of_block;
         stg_diff_in  = diff;
         stg_value_in = req_data.first_of_block ? req_data.sample
                                                : diff[SAMPLE_WIDTH-1:0];
      end else if (q_push) begin
         stg_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_limit_ff <= ONE_BYTE_LIMIT_RST;
         two_limit_ff <= TWO_BYTE_LIMIT_RST;
         prev_ff      <= '0;
         stg_valid_ff <= 1'b0;
      end else begin
         one_limit_ff <= one_limit_in;
         two_limit_ff <= two_limit_in;
         prev_ff      <= prev_in;
         stg_valid_ff <= stg_valid_in;
      end
      stg_first_ff <= stg_first_in;
      stg_diff_ff  <= stg_diff_in;
      stg_value_ff <= stg_value_in;
   end

endmodule

// ===== hw/rtl/dbp_queue.sv =====
module dbp_queue #(
   parameter int Depth = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_push,
   input  dbp_pkg::entry_type        q_wdata,
   input  logic                      q_pop,
   output dbp_pkg::entry_type        q_rdata,
   output dbp_pkg::queue_status_type q_status
);
   import dbp_pkg::*;

   localparam int PtrWidth = $clog2(Depth);
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr  = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] DepthCnt = CntWidth'(Depth);

   entry_type             slots_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;

   assign q_rdata        = slots_ff[rd_ptr_ff];
   assign q_status.full  = (cnt_ff == DepthCnt);
   assign q_status.empty = (cnt_ff == '0);

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (q_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (q_push && !q_pop) begin
         cnt_in = cnt_ff + CntWidth'(1);
      end else if (!q_push && q_pop) begin
         cnt_in = cnt_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (q_push) begin
         slots_ff[wr_ptr_ff] <= q_wdata;
      end
   end

endmodule

// ===== hw/rtl/dbp_back.sv =====
module dbp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  dbp_pkg::entry_type        q_rdata,
   input  dbp_pkg::queue_status_type q_status,
   output logic                      q_pop,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output dbp_pkg::rsp_type          rsp_data
);
   import dbp_pkg::*;

   logic                   busy_ff, busy_in;
   entry_type              ent_ff, ent_in;
   logic [COUNT_WIDTH-1:0] idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   out_free;
   logic                   emit;
   logic                   last;
   logic [BYTE_WIDTH-1:0]  cur_byte;

   assign out_free = !rsp_valid_ff || rsp_pop;
   assign emit     = busy_ff && out_free;
   assign last     = ((idx_ff + COUNT_WIDTH'(1)) == ent_ff.count);
   assign q_pop    = !q_status.empty && (!busy_ff || (emit && last));

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Pick the current byte, low byte first
   always_comb begin
      case (idx_ff)
         2'd0:    cur_byte = ent_ff.value[7:0];
         2'd1:    cur_byte = ent_ff.value[15:8];
         2'd2:    cur_byte = ent_ff.value[23:16];
         default: cur_byte = '0;
      endcase
   end

   // Walk the bytes of the held entry, refill when idle or on its last byte
   always_comb begin
      busy_in      = busy_ff;
      ent_in       = ent_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_byte    = cur_byte;
         rsp_in.width_code  = ent_ff.count;
         rsp_in.last_of_run = last;
         idx_in             = idx_ff + COUNT_WIDTH'(1);
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
      if (q_pop) begin
         busy_in = 1'b1;
         ent_in  = q_rdata;
         idx_in  = '0;
      end else if (emit && last) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ent_ff <= ent_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== hw/rtl/delta_byte_packer.sv =====
// Delta byte packer: turns 24-bit signed samples into a byte stream.
// Request side is a queue input: drive req_data and req_push; a request is
// taken on a clock edge with req_push high and req_full low. A sample marked
// first_of_block goes out whole as three bytes, any other as its difference
// from the previous sample in one, two or three bytes, low byte first.
// Response side is a queue output: while rsp_empty is low, rsp_data holds the
// oldest byte with its width code and last-byte mark; rsp_pop takes it.
// csr_valid/csr_ready write the two byte-count limits; csr_ready is always
// high. Write them only while no request is in flight.
// The first byte of a sample passes the difference stage, the queue and the
// byte walker into the output register before it shows on rsp_data.
// Throughput: one byte per cycle while rsp_pop keeps the output register
// free; the byte walker that feeds the output register sends one to three
// bytes per sample.
// A stalled response side fills the queue (QueueDepth samples) and then the
// difference stage, after which req_full rises; nothing is dropped.
// Reset clears the queue, the output register and the previous sample, and
// loads the limits with 127 and 2047.
module delta_byte_packer #(
   parameter int QueueDepth = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  dbp_pkg::req_type                  req_data,
   output logic                              req_full,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output dbp_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dbp_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [dbp_pkg::SAMPLE_WIDTH-1:0]  csr_wdata
);
   import dbp_pkg::*;

`include "delta_byte_packer_macros.svh"

   logic             q_push;
   logic             q_pop;
   entry_type        q_wdata;
   entry_type        q_rdata;
   queue_status_type q_status;

   assign csr_ready = 1'b1;

   dbp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   dbp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_wdata  (q_wdata),
      .q_pop    (q_pop),
      .q_rdata  (q_rdata),
      .q_status (q_status)
   );

   dbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_rdata   (q_rdata),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // Queue is never written when full nor read when empty
   `DBP_ASSERT_IMPLIES(a_no_push_full, clock, reset, q_push, !q_status.full)
   `DBP_ASSERT_IMPLIES(a_no_pop_empty, clock, reset, q_pop, !q_status.empty)
   // A one-byte sample always carries the last-byte mark
   `DBP_ASSERT_IMPLIES(a_one_is_last, clock, reset,
      !rsp_empty && (rsp_data.width_code == WIDTH_ONE), rsp_data.last_of_run)

endmodule
